// ===== rtl/cfc_pkg.sv =====
`timescale 1ns / 1ps

package cfc_pkg;

    localparam int TDATA_IN_W  = 80;
    localparam int TDATA_OUT_W = 8;

    localparam logic       CMD_HEADER  = 1'b0;
    localparam logic       CMD_PAYLOAD = 1'b1;

    localparam logic [7:0]  MARK_D    = 8'h44;
    localparam logic [7:0]  MARK_S    = 8'h53;
    localparam logic [15:0] FIXED_LEN = 16'h0010;

    localparam logic [3:0] STEP_FIRST     = 4'd0;
    localparam logic [3:0] HDR_LAST_STEP  = 4'd14;
    localparam logic [3:0] HDR_CSUM_STEP  = 4'd15;
    localparam logic [3:0] PAY_CSUM_STEP  = 4'd1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  msg_kind;
        logic [7:0]  data_kind;
        logic [7:0]  dev_kind;
        logic [15:0] src_id;
        logic [15:0] dst_id;
        logic [15:0] payload_len;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    function automatic logic [7:0] header_byte(input logic [3:0] step, input item_t it);
        logic [15:0] total;
        logic [7:0]  info;
        logic [7:0]  b;
        total = it.payload_len + FIXED_LEN;
        info  = {it.msg_kind[3:1], it.data_kind[2:0], it.dev_kind[1:0]};
        case (step)
            4'd0:    b = MARK_D;
            4'd1:    b = MARK_S;
            4'd2:    b = MARK_D;
            4'd3:    b = MARK_S;
            4'd4:    b = info;
            4'd5:    b = total[15:8];
            4'd6:    b = total[7:0];
            4'd7:    b = it.src_id[15:8];
            4'd8:    b = it.src_id[7:0];
            4'd9:    b = it.dst_id[15:8];
            4'd10:   b = it.dst_id[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/cfc_in_reg.sv =====
`timescale 1ns / 1ps

module cfc_in_reg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // msg_kind, data_kind, dev_kind, src_id, dst_id, payload_len, data_byte
    input  logic [cfc_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
    // cmd
    input  logic                             s_axis_tuser,
    input  logic                             take,
    output logic                             item_valid,
    output cfc_pkg::item_t                   item
);
    import cfc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_axis_tready = !valid_reg || take;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.cmd         <= s_axis_tuser;
            item_reg.msg_kind    <= s_axis_tdata[7:0];
            item_reg.data_kind   <= s_axis_tdata[15:8];
            item_reg.dev_kind    <= s_axis_tdata[23:16];
            item_reg.src_id      <= s_axis_tdata[39:24];
            item_reg.dst_id      <= s_axis_tdata[55:40];
            item_reg.payload_len <= s_axis_tdata[71:56];
            item_reg.data_byte   <= s_axis_tdata[79:72];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/cfc_emitter.sv =====
`timescale 1ns / 1ps

module cfc_emitter
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  cfc_pkg::item_t  item,
    input  logic            out_ready,
    output logic            take,
    output logic            emit,
    output cfc_pkg::beat_t  beat
);
    import cfc_pkg::*;

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic [7:0]  hdr_b;

    assign hdr_b = header_byte(step_reg, item);

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        step_next       = step_reg;
        take            = 1'b0;
        emit            = 1'b0;
        beat            = '0;
        if (item_valid)
        begin
            if (item.cmd == CMD_HEADER)
            begin
                if (out_ready)
                begin
                    emit = 1'b1;
                    if (step_reg == HDR_CSUM_STEP)
                    begin
                        beat            = '{data: sum_reg, last: 1'b1};
                        frame_open_next = 1'b0;
                        bytes_left_next = '0;
                        sum_next        = '0;
                        step_next       = STEP_FIRST;
                        take            = 1'b1;
                    end
                    else
                    begin
                        beat     = '{data: hdr_b, last: 1'b0};
                        sum_next = (step_reg == STEP_FIRST) ? hdr_b : sum_reg + hdr_b;
                        if (step_reg == HDR_LAST_STEP && item.payload_len != '0)
                        begin
                            frame_open_next = 1'b1;
                            bytes_left_next = item.payload_len;
                            step_next       = STEP_FIRST;
                            take            = 1'b1;
                        end
                        else
                        begin
                            step_next = step_reg + 4'd1;
                        end
                    end
                end
            end
            else if (!frame_open_reg)
            begin
                // no open frame: drop
                take = 1'b1;
            end
            else if (out_ready)
            begin
                emit = 1'b1;
                if (step_reg == PAY_CSUM_STEP)
                begin
                    beat            = '{data: sum_reg, last: 1'b1};
                    frame_open_next = 1'b0;
                    bytes_left_next = '0;
                    sum_next        = '0;
                    step_next       = STEP_FIRST;
                    take            = 1'b1;
                end
                else
                begin
                    beat            = '{data: item.data_byte, last: 1'b0};
                    sum_next        = sum_reg + item.data_byte;
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (bytes_left_reg == 16'd1)
                    begin
                        step_next = PAY_CSUM_STEP;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
            sum_reg        <= '0;
            step_reg       <= STEP_FIRST;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            step_reg       <= step_next;
        end
    end

    // the checksum of a payload frame is still pending with no bytes left
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_open_reg && step_reg != PAY_CSUM_STEP) |-> bytes_left_reg != 16'd0)
        else $error("open frame with no bytes left");

    a_closed_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> bytes_left_reg == 16'd0)
        else $error("closed frame with bytes left");

    a_payload_step: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item.cmd == CMD_PAYLOAD)
        |-> (step_reg == STEP_FIRST || step_reg == PAY_CSUM_STEP))
        else $error("payload item at header step");

    a_take_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> step_reg == STEP_FIRST)
        else $error("step not reset after item done");

endmodule

// ===== rtl/cfc_out_reg.sv =====
`timescale 1ns / 1ps

module cfc_out_reg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             emit,
    input  cfc_pkg::beat_t                   beat,
    output logic                             out_ready,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_byte
    output logic [cfc_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);
    import cfc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    assign out_ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            beat_reg <= beat;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = beat_reg.data;
    assign m_axis_tlast  = beat_reg.last;

endmodule

// ===== rtl/control_frame_composer.sv =====
// Path: an item is held in the input register while the emitter turns it into bytes for the output register.
// A payload byte gives one output byte (two for the one that ends the frame, adding the
// checksum; none if no frame is open); a header gives 15 output bytes, 16 with an empty payload.
// The single output register sets the rate: one byte leaves per cycle while the receiver is ready.
// Reset: rst_n asynchronous, active low; clears both valid flags and the frame state.
`timescale 1ns / 1ps

module control_frame_composer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // msg_kind, data_kind, dev_kind, src_id, dst_id, payload_len, data_byte
    input  logic [cfc_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
    // cmd
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_byte
    output logic [cfc_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    // last_byte
    output logic                             m_axis_tlast
);
    import cfc_pkg::*;

    logic  take;
    logic  item_valid;
    item_t item;
    logic  out_ready;
    logic  emit;
    beat_t beat;

    cfc_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    cfc_emitter u_emitter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .take       (take),
        .emit       (emit),
        .beat       (beat)
    );

    cfc_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit          (emit),
        .beat          (beat),
        .out_ready     (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== dv/control_frame_composer_test.sv =====
`timescale 1ns / 1ps

module control_frame_composer_test;

    import cfc_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int ITEMS_TARGET = 110;

    class frame_tracker;
        beat_t       due_bytes[$];
        logic        open_q;
        logic [15:0] left_q;
        logic [7:0]  csum;
        int          errors;

        function new();
            open_q = 1'b0;
            left_q = '0;
            csum   = '0;
            errors = 0;
        endfunction

        function void emit(logic [7:0] b, logic is_last);
            beat_t bt;
            bt.data = b;
            bt.last = is_last;
            due_bytes.push_back(bt);
            csum = csum + b;
        endfunction

        function void close_frame();
            beat_t bt;
            bt.data = csum;
            bt.last = 1'b1;
            due_bytes.push_back(bt);
            open_q = 1'b0;
            left_q = '0;
            csum   = '0;
        endfunction

        function void add_item(item_t it);
            logic [7:0]  info;
            logic [15:0] total;
            if (it.cmd == CMD_HEADER)
            begin
                info  = ((it.msg_kind << 4) & 8'hE0) | ((it.data_kind << 2) & 8'h1C)
                      | (it.dev_kind & 8'h03);
                total = it.payload_len + FIXED_LEN;
                csum  = '0;
                emit(MARK_D, 1'b0);
                emit(MARK_S, 1'b0);
                emit(MARK_D, 1'b0);
                emit(MARK_S, 1'b0);
                emit(info, 1'b0);
                emit(total[15:8], 1'b0);
                emit(total[7:0], 1'b0);
                emit(it.src_id[15:8], 1'b0);
                emit(it.src_id[7:0], 1'b0);
                emit(it.dst_id[15:8], 1'b0);
                emit(it.dst_id[7:0], 1'b0);
                repeat (4) emit(8'h00, 1'b0);
                if (it.payload_len == 16'd0)
                    close_frame();
                else
                begin
                    open_q = 1'b1;
                    left_q = it.payload_len;
                end
            end
            else if (open_q)
            begin
                emit(it.data_byte, 1'b0);
                left_q = left_q - 16'd1;
                if (left_q == 16'd0)
                    close_frame();
            end
        endfunction

        function void check_byte(logic [7:0] b, logic is_last);
            beat_t bt;
            if (due_bytes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected byte %02h last=%0b", $realtime, b, is_last);
                return;
            end
            bt = due_bytes.pop_front();
            if (bt.data !== b || bt.last !== is_last)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: byte exp %02h last=%0b, got %02h last=%0b",
                             $realtime, bt.data, bt.last, b, is_last);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    frame_tracker board;
    int           burst_left;
    int           items_sent;
    int           idle_cycles;
    logic [15:0]  rx_cycle;

    control_frame_composer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // accepted items feed the tracker, accepted bytes are checked against it
    always @(posedge clk)
    begin
        item_t it;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_byte(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.cmd         = s_axis_tuser;
                it.msg_kind    = s_axis_tdata[7:0];
                it.data_kind   = s_axis_tdata[15:8];
                it.dev_kind    = s_axis_tdata[23:16];
                it.src_id      = s_axis_tdata[39:24];
                it.dst_id      = s_axis_tdata[55:40];
                it.payload_len = s_axis_tdata[71:56];
                it.data_byte   = s_axis_tdata[79:72];
                board.add_item(it);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** control_frame_composer: FAILED **");
                $finish;
            end
        end
    end

    // receiver stall pattern: free-running, random, sparse, then periodic long stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 16'd1;
            case (rx_cycle[8:7])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2: m_axis_tready <= (rx_cycle[1:0] == 2'd0);
                default: m_axis_tready <= (rx_cycle[4:0] >= 5'd7);
            endcase
        end
    end

    task automatic push_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {it.data_byte, it.payload_len, it.dst_id, it.src_id,
                          it.dev_kind, it.data_kind, it.msg_kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    // header fields not listed are random filler
    task automatic send_header(input logic [7:0] msg, input logic [7:0] dat,
                               input logic [7:0] dev, input logic [15:0] src,
                               input logic [15:0] dst, input logic [15:0] len);
        item_t it;
        it.cmd         = CMD_HEADER;
        it.msg_kind    = msg;
        it.data_kind   = dat;
        it.dev_kind    = dev;
        it.src_id      = src;
        it.dst_id      = dst;
        it.payload_len = len;
        it.data_byte   = 8'($urandom);
        push_item(it);
    endtask

    task automatic send_payload(input logic [7:0] b);
        item_t it;
        it             = item_t'(81'({$urandom, $urandom, $urandom}));
        it.cmd         = CMD_PAYLOAD;
        it.data_byte   = b;
        push_item(it);
    endtask

    task automatic send_random_header(input logic [15:0] len);
        send_header(8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom), 16'($urandom), len);
    endtask

    task automatic random_frame();
        int          pick;
        logic [15:0] len;
        int          n_bytes;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            repeat ($urandom_range(1, 3)) send_payload(8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            len = 16'd0;
        else if (pick < 82)
            len = 16'($urandom_range(1, 8));
        else if (pick < 92)
            len = 16'($urandom_range(9, 40));
        else
            len = 16'($urandom);
        n_bytes = (len > 16'd40) ? $urandom_range(0, 6) : int'(len);
        // broken frame: cut short, the next header abandons it
        if (n_bytes > 0 && $urandom_range(0, 9) == 0)
            n_bytes = $urandom_range(0, n_bytes - 1);
        send_random_header(len);
        repeat (n_bytes) send_payload(8'($urandom));
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_HEADER;
        m_axis_tready = 1'b0;
        rx_cycle      = '0;
        burst_left    = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        send_payload(8'hA5);
        send_header(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_header(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_header(8'h0E, 8'h07, 8'h03, 16'h1234, 16'hABCD, 16'h0001);
        send_payload(8'hFF);
        send_header(8'hF1, 8'hF8, 8'hFC, 16'h8001, 16'h0180, 16'h0002);
        send_payload(8'h00);
        send_payload(8'h80);
        send_header(8'h02, 8'h01, 8'h01, 16'h00FF, 16'hFF00, 16'hFFFF);
        send_payload(8'h5A);
        send_header(8'h04, 8'h02, 8'h02, 16'h5555, 16'hAAAA, 16'hFFF0);
        send_payload(8'hC3);
        send_header(8'h08, 8'h04, 8'h00, 16'hAAAA, 16'h5555, 16'hFFEF);
        send_payload(8'h3C);
        send_header(8'h10, 8'h20, 8'hFC, 16'h0001, 16'h8000, 16'h0003);
        send_payload(8'h01);
        send_payload(8'hFE);
        send_payload(8'h7F);
        send_payload(8'h11);
        send_header(8'h10, 8'hE0, 8'hF0, 16'hFFFF, 16'h0000, 16'h0000);

        while (items_sent < ITEMS_TARGET)
            random_frame();

        s_axis_tvalid <= 1'b0;
        while (board.due_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (board.errors == 0 && board.due_bytes.size() == 0)
            $display("** control_frame_composer: PASSED **");
        else
            $display("** control_frame_composer: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cfc_pkg.sv
rtl/cfc_in_reg.sv
rtl/cfc_emitter.sv
rtl/cfc_out_reg.sv
rtl/control_frame_composer.sv
dv/control_frame_composer_test.sv
